[src/edd_pkg.sv]
// Shared types and constants of the edit distance engine.
package edd_pkg;

  // Default word capacity in bytes
  localparam int MaxLenDefault = 32;

  // Largest value that the distance field can carry
  localparam int DistMax = 63;

  // Request codes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    REQ_FIRST   = 2'd0,
    REQ_SECOND  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_code_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // Request item
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] symbol;
  } req_item_t;

  // Result item
  typedef struct packed {
    logic [5:0] distance;
    logic       overflow;
  } rsp_item_t;

endpackage

[src/edd_stream_if.sv]
// Valid/ready stream channel carrying one item per handshake.
interface edd_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/edd_word_buf.sv]
// Byte buffer holding the first word, one write and one registered read port.
module edd_word_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/edd_cell.sv]
// One column cell of the systolic edit distance row.
module edd_cell #(
  parameter int CW  = 6,
  parameter int COL = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          init,
  input  logic          load,
  input  logic [7:0]    load_sym,
  input  logic          in_valid,
  input  logic [7:0]    in_sym,
  input  logic [CW-1:0] in_left,
  input  logic [CW-1:0] in_diag,
  output logic          out_valid,
  output logic [7:0]    out_sym,
  output logic [CW-1:0] out_left,
  output logic [CW-1:0] out_diag
);

  logic [7:0]    col_sym;
  logic [CW-1:0] up;
  logic [CW:0]   cand_left;
  logic [CW:0]   cand_up;
  logic [CW:0]   cand_diag;
  logic [CW:0]   cand_min;

  // Cost of this column for the row now passing: min of the three edits
  always_comb begin
    cand_left = (CW+1)'(in_left) + (CW+1)'(1);
    cand_up   = (CW+1)'(up) + (CW+1)'(1);
    cand_diag = (CW+1)'(in_diag) + (CW+1)'(in_sym != col_sym);
    cand_min  = (cand_left < cand_up) ? cand_left : cand_up;
    if (cand_diag < cand_min) begin
      cand_min = cand_diag;
    end
  end

  // Row token moves one cell per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  // Column byte, running cost and forwarded data
  always_ff @(posedge clk) begin
    if (load) begin
      col_sym <= load_sym;
    end
    if (init) begin
      up <= CW'(COL);
    end else if (in_valid) begin
      up <= cand_min[CW-1:0];
    end
    if (in_valid) begin
      out_sym  <= in_sym;
      out_diag <= up;
    end
  end

  // New cost of this cell is the left neighbor cost of the next one
  assign out_left = up;

endmodule

[src/edit_distance_engine_unit.sv]
// Edit distance engine top level: request handling, sequencer and cell row.
//
// Computes the Levenshtein distance between two byte words of up to MAX_LEN bytes.
// Append items (first or second word) are taken one per cycle while the engine is
// idle. Bytes of the second word are loaded straight into a row of MAX_LEN cells, one
// per column; bytes of the first word go into a small buffer. A compute item starts
// a pass in which the first word's bytes enter the cell row one per cycle and ripple
// down it, each cell updating its column cost as a row of the cost matrix goes by.
// After a compute item is accepted, the result waits on the feed of the first word
// and the drain through the full cell row; it is held back further while an earlier
// result still waits on the output. No request is accepted until the result is
// loaded. Overflow reports bytes dropped since the last compute; the distance
// saturates at 63.
module edit_distance_engine_unit
  import edd_pkg::*;
#(
  parameter int MAX_LEN = MaxLenDefault
) (
  input logic         clk,
  input logic         rst,
  edd_stream_if.sink   req,
  edd_stream_if.source rsp
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = LW;
  localparam int WW = (CW > 6) ? CW : 6;

  state_t        state;
  state_t        state_next;
  logic [LW-1:0] first_length;
  logic [LW-1:0] second_length;
  logic          truncated_flag;
  logic [LW-1:0] la_r;
  logic [LW-1:0] lb_r;
  logic          trunc_r;
  logic [LW-1:0] rd_idx;
  logic [LW-1:0] drain_cnt;
  logic          feed_valid;
  logic [LW-1:0] feed_row;
  logic [7:0]    feed_sym;
  logic          rsp_valid;
  logic [5:0]    rsp_distance;
  logic          rsp_overflow;

  logic          in_fire;
  logic          is_first;
  logic          is_second;
  logic          is_compute;
  logic          first_full;
  logic          second_full;
  logic          rd_en;
  logic          load_result;
  logic          cell_init;

  logic          link_valid [MAX_LEN+1];
  logic [7:0]    link_sym   [MAX_LEN+1];
  logic [CW-1:0] link_left  [MAX_LEN+1];
  logic [CW-1:0] link_diag  [MAX_LEN+1];
  logic [CW-1:0] cell_cost  [MAX_LEN];

  logic [LW-1:0] lb_m1;
  logic [CW-1:0] dist_full;
  logic [WW-1:0] dist_wide;
  logic [5:0]    dist_sat;

  // Request decode
  assign in_fire     = req.valid && req.ready;
  assign is_first    = req.payload.req_type == REQ_FIRST;
  assign is_second   = req.payload.req_type == REQ_SECOND;
  assign is_compute  = req.payload.req_type == REQ_COMPUTE;
  assign first_full  = first_length == LW'(MAX_LEN);
  assign second_full = second_length == LW'(MAX_LEN);
  assign cell_init   = in_fire && is_compute;

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && is_compute) begin
          state_next = ST_FEED;
        end
      end
      ST_FEED: begin
        if (rd_idx == la_r) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_cnt == LW'(MAX_LEN)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rsp_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req.ready   = state == ST_IDLE;
    rd_en       = (state == ST_FEED) && (rd_idx != la_r);
    load_result = (state == ST_OUT) && (!rsp_valid || rsp.ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      first_length   <= '0;
      second_length  <= '0;
      truncated_flag <= 1'b0;
      rd_idx         <= '0;
      drain_cnt      <= '0;
      feed_valid     <= 1'b0;
      rsp_valid      <= 1'b0;
    end else begin
      state      <= state_next;
      feed_valid <= rd_en;
      if (state == ST_DRAIN) begin
        drain_cnt <= drain_cnt + LW'(1);
      end else begin
        drain_cnt <= '0;
      end
      if (cell_init) begin
        rd_idx <= '0;
      end else if (rd_en) begin
        rd_idx <= rd_idx + LW'(1);
      end
      if (in_fire) begin
        if (is_first) begin
          if (first_full) begin
            truncated_flag <= 1'b1;
          end else begin
            first_length <= first_length + LW'(1);
          end
        end else if (is_second) begin
          if (second_full) begin
            truncated_flag <= 1'b1;
          end else begin
            second_length <= second_length + LW'(1);
          end
        end else if (is_compute) begin
          first_length   <= '0;
          second_length  <= '0;
          truncated_flag <= 1'b0;
        end
      end
      if (load_result) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Snapshot of the word lengths at compute, row number, result
  always_ff @(posedge clk) begin
    if (cell_init) begin
      la_r    <= first_length;
      lb_r    <= second_length;
      trunc_r <= truncated_flag;
    end
    if (rd_en) begin
      feed_row <= rd_idx + LW'(1);
    end
    if (load_result) begin
      rsp_distance <= dist_sat;
      rsp_overflow <= trunc_r;
    end
  end

  // First word storage
  edd_word_buf #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_first_buf (
    .clk     (clk),
    .wr_en   (in_fire && is_first && !first_full),
    .wr_addr (first_length[AW-1:0]),
    .wr_data (req.payload.symbol),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (feed_sym)
  );

  // Head of the row: row number i enters with left cost i and diagonal i-1
  assign link_valid[0] = feed_valid;
  assign link_sym[0]   = feed_sym;
  assign link_left[0]  = feed_row;
  assign link_diag[0]  = feed_row - LW'(1);

  // Cell row, one cell per column of the second word
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    edd_cell #(
      .CW  (CW),
      .COL (k + 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .init      (cell_init),
      .load      (in_fire && is_second && (second_length == LW'(k))),
      .load_sym  (req.payload.symbol),
      .in_valid  (link_valid[k]),
      .in_sym    (link_sym[k]),
      .in_left   (link_left[k]),
      .in_diag   (link_diag[k]),
      .out_valid (link_valid[k+1]),
      .out_sym   (link_sym[k+1]),
      .out_left  (link_left[k+1]),
      .out_diag  (link_diag[k+1])
    );
    assign cell_cost[k] = link_left[k+1];
  end

  // Pick the cost at the last column of the second word, then saturate
  always_comb begin
    lb_m1     = lb_r - LW'(1);
    dist_full = (lb_r == '0) ? la_r : cell_cost[lb_m1[AW-1:0]];
    dist_wide = WW'(dist_full);
    dist_sat  = (dist_wide > WW'(DistMax)) ? 6'(DistMax) : dist_wide[5:0];
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.payload.distance = rsp_distance;
  assign rsp.payload.overflow = rsp_overflow;

`ifndef SYNTH
  // A compute item starts the feed pass
  a_compute_starts_feed: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.payload.req_type == REQ_COMPUTE) |=> state == ST_FEED)
    else $error("compute item did not start the feed pass");

  // Row tokens enter the cell row only out of the feed pass
  a_feed_from_feed_state: assert property (@(posedge clk) disable iff (rst)
    feed_valid |-> $past(state) == ST_FEED)
    else $error("row token entered outside the feed pass");

  // The read pointer never passes the captured first word length
  a_rd_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_FEED |-> rd_idx <= la_r)
    else $error("feed read pointer passed the first word length");

  // A result is loaded only while the output slot is free or being emptied
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !load_result)
    else $error("result loaded over a pending result");
`endif

endmodule

[bench/edit_distance_engine_unit_tb.sv]
// Self-checking testbench for the edit distance engine: stream stimulus, predictor, scoreboard.
module edit_distance_engine_unit_tb;
  import edd_pkg::*;

  localparam int WordCap = MaxLenDefault;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 9;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 3000;
  localparam int unsigned ItemTarget = 1800;
  localparam int unsigned CalmFrom = 1500;
  localparam int unsigned PressureAt = 600;

  // Predicts distance/overflow for each compute item and checks the results
  class edit_distance_scoreboard;
    logic [7:0] first_word [WordCap];
    logic [7:0] second_word [WordCap];
    int unsigned first_len;
    int unsigned second_len;
    bit dropped;
    rsp_item_t expected_q [$];
    int unsigned error_count;

    function new();
      first_len = 0;
      second_len = 0;
      dropped = 1'b0;
      error_count = 0;
    endfunction

    // Row-by-row Levenshtein cost over the loaded words
    function int unsigned edit_cost();
      int unsigned cost [WordCap + 1];
      int unsigned diag, up, sub, best;
      for (int j = 0; j <= second_len; j++) cost[j] = j;
      for (int i = 1; i <= first_len; i++) begin
        diag = cost[0];
        cost[0] = i;
        for (int j = 1; j <= second_len; j++) begin
          up = cost[j];
          sub = (first_word[i - 1] == second_word[j - 1]) ? 0 : 1;
          best = cost[j - 1] + 1;
          if (up + 1 < best) best = up + 1;
          if (diag + sub < best) best = diag + sub;
          cost[j] = best;
          diag = up;
        end
      end
      return cost[second_len];
    endfunction

    // Update the word state for one accepted request item
    function void note_request(req_item_t it);
      rsp_item_t exp_item;
      int unsigned d;
      case (it.req_type)
        REQ_FIRST: begin
          if (first_len < WordCap) begin
            first_word[first_len] = it.symbol;
            first_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        REQ_SECOND: begin
          if (second_len < WordCap) begin
            second_word[second_len] = it.symbol;
            second_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        REQ_COMPUTE: begin
          d = edit_cost();
          if (d > DistMax) d = DistMax;
          exp_item.distance = d[5:0];
          exp_item.overflow = dropped;
          expected_q = {expected_q, exp_item};
          first_len = 0;
          second_len = 0;
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(rsp_item_t got);
      rsp_item_t exp_item;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with none pending: distance %0d overflow %0d",
                                  got.distance, got.overflow));
      end else begin
        exp_item = expected_q.pop_front();
        if (got.distance !== exp_item.distance)
          report_mismatch($sformatf("distance %0d, want %0d", got.distance,
                                    exp_item.distance));
        if (got.overflow !== exp_item.overflow)
          report_mismatch($sformatf("overflow %0d, want %0d", got.overflow,
                                    exp_item.overflow));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit calm;
  bit rsp_hold_req;
  int unsigned sent_count;
  edit_distance_scoreboard sb = new();

  edd_stream_if #(.item_t(req_item_t)) req_if ();
  edd_stream_if #(.item_t(rsp_item_t)) rsp_if ();

  edit_distance_engine_unit #(
    .MAX_LEN(WordCap)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Clock
  initial clk = 1'b0;
  always #HalfPeriod clk = ~clk;

  // Offer one request item, optionally after a short idle burst, and wait for acceptance
  task automatic send_item(input logic [1:0] code, input logic [7:0] sym);
    req_item_t it;
    it.req_type = code;
    it.symbol = sym;
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_if.payload <= it;
    req_if.valid <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(it);
    if (code != REQ_UNUSED) sent_count++;
  endtask

  // Mostly a small alphabet so that bytes match often
  function automatic logic [7:0] pick_symbol(input logic [7:0] alpha [3]);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return alpha[$urandom_range(0, 2)];
  endfunction

  // Field extremes, every request code, empty words and the ignored code
  task automatic run_directed();
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_FIRST, 8'h00);
    send_item(REQ_FIRST, 8'hFF);
    send_item(REQ_COMPUTE, 8'hFF);
    send_item(REQ_SECOND, 8'hFF);
    send_item(REQ_SECOND, 8'h00);
    send_item(REQ_SECOND, 8'h5A);
    send_item(REQ_COMPUTE, 8'hA5);
    send_item(REQ_UNUSED, 8'hA5);
    send_item(REQ_FIRST, 8'h80);
    send_item(REQ_SECOND, 8'h80);
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_FIRST, 8'h01);
    send_item(REQ_FIRST, 8'h02);
    send_item(REQ_SECOND, 8'h02);
    send_item(REQ_SECOND, 8'h01);
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_UNUSED, 8'hFF);
    send_item(REQ_UNUSED, 8'h00);
    send_item(REQ_COMPUTE, 8'h7E);
  endtask

  // Full words: one byte past capacity on each side, all bytes different,
  // then equal words with only the second one overflowing
  task automatic run_full_words();
    for (int k = 0; k <= WordCap; k++) send_item(REQ_FIRST, 8'(k));
    for (int k = 0; k <= WordCap; k++) send_item(REQ_SECOND, 8'h80 | 8'(k));
    send_item(REQ_COMPUTE, 8'h00);
    for (int k = 0; k < WordCap; k++) send_item(REQ_FIRST, 8'hC0 ^ 8'(k));
    for (int k = 0; k <= WordCap + 1; k++) send_item(REQ_SECOND, 8'hC0 ^ 8'(k));
    send_item(REQ_COMPUTE, 8'h00);
    send_item(REQ_COMPUTE, 8'h00);
  endtask

  // One word pair with interleaved appends and a compute; sometimes a noise burst instead
  task automatic run_word_pair();
    int unsigned kind, len_a, len_b, na, nb;
    logic [7:0] alpha [3];
    logic [7:0] word_a [$];
    logic [7:0] word_b [$];
    kind = $urandom_range(0, 19);
    foreach (alpha[k]) alpha[k] = 8'($urandom_range(0, 255));
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
      return;
    end
    if (kind == 1) begin
      len_a = $urandom_range(WordCap - 4, WordCap + 3);
      len_b = $urandom_range(WordCap - 4, WordCap + 3);
    end else begin
      len_a = $urandom_range(0, 8);
      len_b = $urandom_range(0, 8);
    end
    for (int k = 0; k < len_a; k++) word_a = {word_a, pick_symbol(alpha)};
    // second word is often an edited copy of the first
    for (int k = 0; k < len_b; k++) begin
      if (kind >= 10 && k < len_a && $urandom_range(0, 3) != 0) begin
        word_b = {word_b, word_a[k]};
      end else begin
        word_b = {word_b, pick_symbol(alpha)};
      end
    end
    na = 0;
    nb = 0;
    while (na < len_a || nb < len_b) begin
      if ($urandom_range(0, 24) == 0) send_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
      if (nb >= len_b || (na < len_a && $urandom_range(0, 1) == 0)) begin
        send_item(REQ_FIRST, word_a[na]);
        na++;
      end else begin
        send_item(REQ_SECOND, word_b[nb]);
        nb++;
      end
    end
    send_item(REQ_COMPUTE, 8'($urandom_range(0, 255)));
  endtask

  // Result side: random stall bursts, one long hold-off on request
  initial begin : rsp_side
    int stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) sb.check_result(rsp_if.payload);
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        stall_left = HoldCycles;
      end
      if (rst) begin
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too long without any accepted item
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    bit pressure_done;
    pressure_done = 1'b0;
    calm = 1'b0;
    rsp_hold_req = 1'b0;
    sent_count = 0;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.payload <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    run_full_words();
    while (sent_count < ItemTarget) begin
      if (!pressure_done && sent_count >= PressureAt) begin
        rsp_hold_req = 1'b1;
        pressure_done = 1'b1;
      end
      if (sent_count >= CalmFrom) calm = 1'b1;
      run_word_pair();
    end
    req_if.valid <= 1'b0;

    // drain the outstanding results, then a quiet tail for stray ones
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2 * WordCap + 8) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
src/edd_pkg.sv
src/edd_stream_if.sv
src/edd_word_buf.sv
src/edd_cell.sv
src/edit_distance_engine_unit.sv
bench/edit_distance_engine_unit_tb.sv
